// File: design/uzpd_pkg.sv
// Package for the zero-padded decimal formatter: widths, codes and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package uzpd_pkg;

   // field widths
   localparam int VALUE_W   = 64;
   localparam int WIDTH_W   = 6;
   localparam int CAP_W     = 7;
   localparam int CHAR_W    = 8;
   localparam int LEN_W     = 6;
   localparam int DIGITS    = 20;
   localparam int DIG_IDX_W = $clog2(DIGITS);
   localparam int COUNT_W   = $clog2(VALUE_W);

   // packed port widths, padded to whole bytes
   localparam int REQ_DATA_W = ((VALUE_W + WIDTH_W + CAP_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((CHAR_W + LEN_W + 7) / 8) * 8;

   // constants
   localparam int                 MAX_WIDTH_DEF = 63;
   localparam logic [CAP_W-1:0]   CAP_SAT       = 7'd64;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_NUL      = 8'h00;

   // kind of byte placed in the output register
   typedef enum logic [1:0] {
      EMIT_PAD   = 2'd0,
      EMIT_DIGIT = 2'd1,
      EMIT_TERM  = 2'd2,
      EMIT_FAIL  = 2'd3
   } emit_kind_type;

   // controller to datapath
   typedef struct packed {
      logic                 load;
      logic                 shift;
      logic                 emit;
      emit_kind_type        kind;
      logic [DIG_IDX_W-1:0] dig_sel;
      logic [LEN_W-1:0]     length;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic                 out_free;
      logic [DIG_IDX_W-1:0] ndig;
      logic [WIDTH_W-1:0]   width;
      logic [CAP_W-1:0]     cap;
   } status_type;

endpackage

// File: design/u64_zero_padded_decimal.sv
// Top level of the zero-padded decimal formatter: joins controller and
// datapath. Depends on uzpd_pkg, uzpd_ctrl and uzpd_datapath.
`timescale 1ns / 1ps

// Formats an unsigned 64-bit value as zero-padded decimal ASCII, one byte
// per output word: padding zeros, digits most significant first, then a NUL
// word with tlast set and the field length in tdata[13:8]. When the field
// plus terminator does not fit the capacity, a single NUL word with tlast
// and tuser set is sent instead. One item is handled at a time: after the
// input word is taken, the shift-add-3 BCD register takes in the value
// (one value bit per cycle), the sizing state sizes the field, and then
// one byte leaves per cycle with rsp_tready held high. The next input
// word is taken as soon as the last byte sits in the output register.

module u64_zero_padded_decimal
   import uzpd_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // value [63:0], min_width [69:64], capacity [76:70], zeros above
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_char [7:0], length [13:8], zeros above
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   // fail [0]
   output logic                  rsp_tuser
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   uzpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // conversion and output register
   uzpd_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: design/uzpd_datapath.sv
// Datapath of the formatter: operand registers, shift-add-3 BCD register,
// digit count and the output word register. Depends on uzpd_pkg.
`timescale 1ns / 1ps

module uzpd_datapath
   import uzpd_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  cmd_type               cmd,
   output status_type            status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   localparam logic [WIDTH_W-1:0] MaxWidthW = WIDTH_W'(MAX_WIDTH);

   logic [VALUE_W-1:0]           value_ff, value_in;
   logic [DIGITS-1:0][3:0]       bcd_ff, bcd_in;
   logic [DIGITS-1:0][3:0]       bcd_adj;
   logic [WIDTH_W-1:0]           width_ff, width_in;
   logic [CAP_W-1:0]             cap_ff, cap_in;
   logic [DIG_IDX_W-1:0]         ndig;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]            char_ff, char_in;
   logic                         last_ff, last_in;
   logic                         fail_ff, fail_in;
   logic [LEN_W-1:0]             len_ff, len_in;
   logic                         out_free;

   logic [VALUE_W-1:0]           req_value;
   logic [WIDTH_W-1:0]           req_width;
   logic [CAP_W-1:0]             req_cap;

   assign req_value = req_tdata[VALUE_W-1:0];
   assign req_width = req_tdata[VALUE_W+WIDTH_W-1:VALUE_W];
   assign req_cap   = req_tdata[VALUE_W+WIDTH_W+CAP_W-1:VALUE_W+WIDTH_W];

   // add 3 to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? (bcd_ff[i] + 4'd3) : bcd_ff[i];
      end
   end

   // operand load with saturation, one bit per shift
   always_comb begin
      value_in = value_ff;
      bcd_in   = bcd_ff;
      width_in = width_ff;
      cap_in   = cap_ff;
      if (cmd.load) begin
         value_in = req_value;
         bcd_in   = '0;
         width_in = (req_width > MaxWidthW) ? MaxWidthW : req_width;
         cap_in   = (req_cap > CAP_SAT) ? CAP_SAT : req_cap;
      end else if (cmd.shift) begin
         value_in = {value_ff[VALUE_W-2:0], 1'b0};
         bcd_in   = {bcd_adj[DIGITS-1][2:0], bcd_adj[DIGITS-2:0], value_ff[VALUE_W-1]};
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      bcd_ff   <= bcd_in;
      width_ff <= width_in;
      cap_ff   <= cap_in;
   end

   // digit count: highest nonzero digit, zero gives one digit
   always_comb begin
      ndig = DIG_IDX_W'(1);
      for (int i = 1; i < DIGITS; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            ndig = DIG_IDX_W'(i + 1);
         end
      end
   end

   // output word register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      fail_in      = fail_ff;
      len_in       = len_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         last_in      = 1'b0;
         fail_in      = 1'b0;
         len_in       = '0;
         case (cmd.kind)
            EMIT_PAD: begin
               char_in = CHAR_ZERO;
            end
            EMIT_DIGIT: begin
               char_in = {4'h3, bcd_ff[cmd.dig_sel]};
            end
            EMIT_TERM: begin
               char_in = CHAR_NUL;
               last_in = 1'b1;
               len_in  = cmd.length;
            end
            EMIT_FAIL: begin
               char_in = CHAR_NUL;
               last_in = 1'b1;
               fail_in = 1'b1;
            end
            default: begin
               char_in = CHAR_NUL;
            end
         endcase
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
      fail_ff <= fail_in;
      len_ff  <= len_in;
   end

   assign status.out_free = out_free;
   assign status.ndig     = ndig;
   assign status.width    = width_ff;
   assign status.cap      = cap_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({len_ff, char_ff});
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = fail_ff;

   // an error word is always a lone last word with no payload
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && fail_ff |-> last_ff && char_ff == CHAR_NUL && len_ff == '0)
      else $error("error word malformed");

   // only the terminator carries a length
   a_len_term: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !last_ff |-> len_ff == '0)
      else $error("length on non-terminator word");

endmodule

// File: design/uzpd_ctrl.sv
// Controller of the formatter: sequences load, 64 conversion steps, sizing
// and byte emission. Depends on uzpd_pkg.
`timescale 1ns / 1ps

module uzpd_ctrl
   import uzpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_CONVERT = 7'b0000010,
      ST_SIZE    = 7'b0000100,
      ST_FAIL    = 7'b0001000,
      ST_PAD     = 7'b0010000,
      ST_DIGIT   = 7'b0100000,
      ST_TERM    = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [LEN_W-1:0]     pad_ff, pad_in;
   logic [DIG_IDX_W-1:0] dig_ff, dig_in;
   logic [LEN_W-1:0]     field_ff, field_in;
   logic [LEN_W-1:0]     ndig_w;
   logic [LEN_W-1:0]     field_w;
   logic                 fits;

   // field size and fit test
   assign ndig_w  = LEN_W'(status.ndig);
   assign field_w = (status.width > ndig_w) ? status.width : ndig_w;
   assign fits    = ({1'b0, field_w} + CAP_W'(1)) <= status.cap;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pad_in      = pad_ff;
      dig_in      = dig_ff;
      field_in    = field_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      cmd.kind    = EMIT_PAD;
      cmd.dig_sel = dig_ff;
      cmd.length  = field_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
            count_in  = count_ff + COUNT_W'(1);
            if (count_ff == '1) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            field_in = field_w;
            pad_in   = field_w - ndig_w;
            dig_in   = status.ndig - DIG_IDX_W'(1);
            if (!fits) begin
               state_in = ST_FAIL;
            end else if (field_w != ndig_w) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_FAIL: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_FAIL;
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_PAD;
               pad_in   = pad_ff - LEN_W'(1);
               if (pad_ff == LEN_W'(1)) begin
                  state_in = ST_DIGIT;
               end
            end
         end
         ST_DIGIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_DIGIT;
               if (dig_ff == '0) begin
                  state_in = ST_TERM;
               end else begin
                  dig_in = dig_ff - DIG_IDX_W'(1);
               end
            end
         end
         ST_TERM: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_TERM;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pad_ff   <= pad_in;
      dig_ff   <= dig_in;
      field_ff <= field_in;
   end

   // a word is only placed when the output register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("emit into a full output register");

   // padding state always has padding left
   a_pad_left: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAD |-> pad_ff != '0)
      else $error("pad state with nothing to pad");

   // digit index stays below the digit count
   a_dig_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIGIT |-> dig_ff < status.ndig)
      else $error("digit index out of range");

endmodule
